>>> rtl/core/ssgd_pkg.sv
// Shared constants, pattern tables and code names for the sensor sequence
// gesture detector. Used by the top level and its assertion checker.
// No dependencies.
`default_nettype none

package ssgd_pkg;

    // Number of sensors kept in the history and edge tracking
    localparam int SENSORS_DEF   = 4;
    localparam int SENSORS_MIN   = 4;
    localparam int SENSORS_MAX   = 8;

    // Field widths
    localparam int FUNC_W        = 1;
    localparam int INDEX_W       = 2;
    localparam int ECHO_W        = 15;
    localparam int CODE_W        = 3;
    localparam int ENTRY_W       = 3;
    localparam int THRESH_W      = 10;
    localparam int COUNT_W       = 16;
    localparam int LIMIT_W       = THRESH_W + 6;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 24;
    localparam int S_TUSER_W     = 1;
    localparam int M_TDATA_W     = 8;

    // Echo scaling and range
    localparam int US_PER_CM     = 58;
    localparam logic [ECHO_W-1:0] ECHO_LIMIT_US = ECHO_W'(30000);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(200);
    localparam logic [COUNT_W-1:0]  TIMEOUT_RST   = COUNT_W'(2000);
    localparam logic [COUNT_W-1:0]  COOLDOWN_RST  = COUNT_W'(500);

    // Input kind carried in tuser
    localparam logic FUNC_READING = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // Event codes: patterns map to their own position, then the timeout
    localparam logic [CODE_W-1:0] EV_STOP     = 3'd0;
    localparam logic [CODE_W-1:0] EV_PLAY     = 3'd1;
    localparam logic [CODE_W-1:0] EV_PREVIOUS = 3'd2;
    localparam logic [CODE_W-1:0] EV_NEXT     = 3'd3;
    localparam logic [CODE_W-1:0] EV_VOL_UP   = 3'd4;
    localparam logic [CODE_W-1:0] EV_VOL_DOWN = 3'd5;
    localparam logic [CODE_W-1:0] EV_TIMEOUT  = 3'd6;

    // Gesture patterns, newest entry last, aligned to the newest end
    localparam int PATTERN_COUNT = 6;
    localparam int PATTERN_SPAN  = 4;

    localparam logic [ENTRY_W-1:0] PAT_SEQ [PATTERN_COUNT][PATTERN_SPAN] = '{
        '{3'd0, 3'd0, 3'd1, 3'd3},
        '{3'd0, 3'd0, 3'd3, 3'd1},
        '{3'd0, 3'd0, 3'd2, 3'd4},
        '{3'd0, 3'd0, 3'd4, 3'd2},
        '{3'd1, 3'd2, 3'd3, 3'd4},
        '{3'd1, 3'd4, 3'd3, 3'd2}
    };

    localparam int PAT_LEN [PATTERN_COUNT] = '{2, 2, 2, 2, 4, 4};

endpackage

`default_nettype wire

>>> rtl/core/sensor_sequence_gesture_detector_unit.sv
// Top level of the sensor sequence gesture detector: input register, edge
// detect, history shift, pattern match and a registered result.
// Depends on ssgd_pkg.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: sensor_index, echo_us
// m_*       out  m_tvalid/m_tready  tdata: event_code
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item a cycle sustained unless a result waits with m_tready low. An item
// is registered, then one combinational pass updates history, edge flags and
// counters and loads the result register.
// s_tready drops only while a result waits and m_tready is low.
// rst_n clears the history, edge flags, counters and valids, and loads the config regs with their reset values.
// cfg_ready is always high; writes to indexes beyond the list are ignored.

module sensor_sequence_gesture_detector_unit #(
    parameter int SENSORS = ssgd_pkg::SENSORS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ssgd_pkg::S_TDATA_W-1:0]   s_tdata,   // [1:0] sensor_index, [16:2] echo_us
    input  wire logic [ssgd_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] func
    // master stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ssgd_pkg::M_TDATA_W-1:0]        m_tdata,   // [2:0] event_code
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ssgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ssgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ssgd_pkg::*;

    localparam int SIDX_W = $clog2(SENSORS);

    // Configuration registers
    logic [THRESH_W-1:0] threshold_reg;
    logic [COUNT_W-1:0]  timeout_reg;
    logic [COUNT_W-1:0]  cooldown_reg;

    // Input register
    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic [ECHO_W-1:0]   s1_echo_reg;

    // Detector state
    logic [ENTRY_W-1:0]  hist_reg [SENSORS];
    logic [ENTRY_W-1:0]  hist_next [SENSORS];
    logic [SENSORS-1:0]  in_range_reg;
    logic [SENSORS-1:0]  in_range_next;
    logic [COUNT_W-1:0]  since_trig_reg;
    logic [COUNT_W-1:0]  since_trig_next;
    logic [COUNT_W-1:0]  since_cmd_reg;
    logic [COUNT_W-1:0]  since_cmd_next;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CODE_W-1:0]   out_code_reg;
    logic [CODE_W-1:0]   out_code_next;

    // Pass control
    logic                out_free;
    logic                advance;
    logic                s_accept;

    // Combinational pass
    logic [LIMIT_W-1:0]  echo_limit;
    logic                near;
    logic                cooling;
    logic                fire;
    logic [SIDX_W-1:0]   sidx;
    logic [ENTRY_W-1:0]  hist_shift [SENSORS];
    logic                hit;
    logic [CODE_W-1:0]   hit_code;
    logic [COUNT_W-1:0]  trig_inc;
    logic [COUNT_W-1:0]  cmd_inc;
    logic                timed_out;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_code_reg);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            timeout_reg   <= TIMEOUT_RST;
            cooldown_reg  <= COOLDOWN_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_THRESHOLD)
            begin
                threshold_reg <= cfg_data[THRESH_W-1:0];
            end
            if (cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_index == CFG_COOLDOWN)
            begin
                cooldown_reg <= cfg_data;
            end
        end
    end

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_func_reg  <= s_tuser[0];
            s1_index_reg <= s_tdata[INDEX_W-1:0];
            s1_echo_reg  <= s_tdata[INDEX_W+ECHO_W-1:INDEX_W];
        end
    end

    // Range test: floor(echo/58) < threshold is echo < threshold*58
    assign echo_limit = LIMIT_W'(threshold_reg) * LIMIT_W'(US_PER_CM);
    assign near       = (s1_echo_reg != '0) && (s1_echo_reg <= ECHO_LIMIT_US)
                        && (LIMIT_W'(s1_echo_reg) < echo_limit);
    assign cooling    = since_cmd_reg < cooldown_reg;
    assign sidx       = SIDX_W'(s1_index_reg);
    assign fire       = near && !in_range_reg[sidx] && !cooling;

    // Saturating counter increments for a tick
    assign trig_inc  = (since_trig_reg == '1) ? since_trig_reg : since_trig_reg + 1'b1;
    assign cmd_inc   = (since_cmd_reg == '1) ? since_cmd_reg : since_cmd_reg + 1'b1;
    assign timed_out = (hist_reg[SENSORS-1] != '0) && (trig_inc >= timeout_reg);

    // Shift the new sensor number into the newest slot
    always_comb
    begin
        for (int i = 0; i < SENSORS - 1; i++)
        begin
            hist_shift[i] = hist_reg[i+1];
        end
        hist_shift[SENSORS-1] = ENTRY_W'(s1_index_reg) + ENTRY_W'(1);
    end

    // Match the patterns; the lowest numbered match wins
    always_comb
    begin
        logic ok;
        hit      = 1'b0;
        hit_code = EV_STOP;
        for (int g = PATTERN_COUNT - 1; g >= 0; g--)
        begin
            ok = 1'b1;
            for (int i = 0; i < PATTERN_SPAN; i++)
            begin
                if (i >= PATTERN_SPAN - PAT_LEN[g])
                begin
                    ok = ok && (hist_shift[SENSORS-PATTERN_SPAN+i] == PAT_SEQ[g][i]);
                end
            end
            if (ok)
            begin
                hit      = 1'b1;
                hit_code = CODE_W'(g);
            end
        end
    end

    // Next state for one item
    always_comb
    begin
        hist_next       = hist_reg;
        in_range_next   = in_range_reg;
        since_trig_next = since_trig_reg;
        since_cmd_next  = since_cmd_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_code_next   = out_code_reg;
        if (advance)
        begin
            if (s1_func_reg == FUNC_TICK)
            begin
                since_trig_next = trig_inc;
                since_cmd_next  = cmd_inc;
                if (timed_out)
                begin
                    for (int i = 0; i < SENSORS; i++)
                    begin
                        hist_next[i] = '0;
                    end
                    out_valid_next = 1'b1;
                    out_code_next  = EV_TIMEOUT;
                end
            end
            else
            begin
                in_range_next[sidx] = near;
                if (fire)
                begin
                    since_trig_next = '0;
                    if (hit)
                    begin
                        for (int i = 0; i < SENSORS; i++)
                        begin
                            hist_next[i] = '0;
                        end
                        since_cmd_next = '0;
                        out_valid_next = 1'b1;
                        out_code_next  = hit_code;
                    end
                    else
                    begin
                        hist_next = hist_shift;
                    end
                end
            end
        end
    end

    // Hold detector state and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                hist_reg[i] <= '0;
            end
            in_range_reg   <= '0;
            since_trig_reg <= '0;
            since_cmd_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hist_reg       <= hist_next;
            in_range_reg   <= in_range_next;
            since_trig_reg <= since_trig_next;
            since_cmd_reg  <= since_cmd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/ssgd_checker.sv
// Port-level assertion checker for the gesture detector top level, with
// the bind that attaches it. Depends on ssgd_pkg.
`default_nettype none

module ssgd_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [ssgd_pkg::M_TDATA_W-1:0]   m_tdata
);

    import ssgd_pkg::*;

    // A result waiting on the output holds its code
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Event codes stay within the defined set
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[CODE_W-1:0] <= EV_TIMEOUT)
                     && (m_tdata[M_TDATA_W-1:CODE_W] == '0))
        else $error("event code out of range");

    // Input backs up only behind a waiting result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // A fresh result follows an accepted item, by way of the input register and the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding item");

endmodule

bind sensor_sequence_gesture_detector_unit ssgd_checker u_ssgd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_sensor_sequence_gesture_detector_unit.sv
// Testbench for the sensor sequence gesture detector: drives readings and ticks,
// predicts each event code from its own copy of the state, and checks the results.
// Depends on ssgd_pkg and sensor_sequence_gesture_detector_unit.
`timescale 1ns / 100ps

module tb_sensor_sequence_gesture_detector_unit;

    import ssgd_pkg::*;

    // Echo scaling used by the prediction
    localparam int CM_DIVISOR  = 58;
    localparam int ECHO_VALID  = 30000;
    localparam int ECHO_TOP    = 32767;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASES      = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [1:0] sensor_index, [16:2] echo_us
    logic [S_TUSER_W-1:0]   s_tuser;    // [0] func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // [2:0] event_code
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted detector state and registers
    logic [2:0]        sensor_hist [4];
    logic              hand_near [4];
    logic [15:0]       ms_since_trig = '0;
    logic [15:0]       ms_since_cmd  = '0;
    logic [9:0]        thr_cm        = 10'd200;
    logic [15:0]       timeout_ms    = 16'd2000;
    logic [15:0]       cooldown_len  = 16'd500;

    // Event codes still owed by the block, oldest first
    logic [CODE_W-1:0] pending_events [$];
    logic [CODE_W-1:0] event_want;

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    sensor_sequence_gesture_detector_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("[sensor_sequence_gesture_detector_unit] ERROR");
        $finish;
    end

    // Stall the result side at the current rate
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest owed event
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_code expected none actual %0d", m_tdata[CODE_W-1:0]);
                mismatch_count++;
            end
            else
            begin
                event_want = pending_events.pop_front();
                if (m_tdata[CODE_W-1:0] !== event_want)
                begin
                    $error("event_code expected %0d actual %0d", event_want,
                           m_tdata[CODE_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Advance the predicted state by one accepted item
    task automatic predict_event(input logic kind, input logic [1:0] idx,
                                 input logic [14:0] echo);
        logic near_now;
        logic fire;
        logic [CODE_W-1:0] code;
        if (kind == FUNC_TICK)
        begin
            if (ms_since_trig != COUNT_TOP)
                ms_since_trig++;
            if (ms_since_cmd != COUNT_TOP)
                ms_since_cmd++;
            if (sensor_hist[3] != 3'd0 && ms_since_trig >= timeout_ms)
            begin
                foreach (sensor_hist[k])
                    sensor_hist[k] = 3'd0;
                pending_events.push_back(EV_TIMEOUT);
            end
        end
        else
        begin
            near_now = (echo != 0) && (int'(echo) <= ECHO_VALID) &&
                       ((int'(echo) / CM_DIVISOR) < int'(thr_cm));
            fire = near_now && !hand_near[idx] && !(ms_since_cmd < cooldown_len);
            hand_near[idx] = near_now;
            if (fire)
            begin
                // Shift the sensor number in, newest last
                sensor_hist[0] = sensor_hist[1];
                sensor_hist[1] = sensor_hist[2];
                sensor_hist[2] = sensor_hist[3];
                sensor_hist[3] = 3'(idx) + 3'd1;
                ms_since_trig = '0;
                code = '0;
                fire = 1'b1;
                if (sensor_hist[2] == 3'd1 && sensor_hist[3] == 3'd3)
                    code = EV_STOP;
                else if (sensor_hist[2] == 3'd3 && sensor_hist[3] == 3'd1)
                    code = EV_PLAY;
                else if (sensor_hist[2] == 3'd2 && sensor_hist[3] == 3'd4)
                    code = EV_PREVIOUS;
                else if (sensor_hist[2] == 3'd4 && sensor_hist[3] == 3'd2)
                    code = EV_NEXT;
                else if (sensor_hist[0] == 3'd1 && sensor_hist[1] == 3'd2 &&
                         sensor_hist[2] == 3'd3 && sensor_hist[3] == 3'd4)
                    code = EV_VOL_UP;
                else if (sensor_hist[0] == 3'd1 && sensor_hist[1] == 3'd4 &&
                         sensor_hist[2] == 3'd3 && sensor_hist[3] == 3'd2)
                    code = EV_VOL_DOWN;
                else
                    fire = 1'b0;
                if (fire)
                begin
                    foreach (sensor_hist[k])
                        sensor_hist[k] = 3'd0;
                    ms_since_cmd = '0;
                    pending_events.push_back(code);
                end
            end
        end
    endtask

    // Send one item, with random idle cycles ahead of it
    task automatic send_item(input logic kind, input logic [1:0] idx,
                             input logic [14:0] echo);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = S_TDATA_W'($urandom);
            s_tuser  = S_TUSER_W'($urandom);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {7'd0, echo, idx};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        predict_event(kind, idx, echo);
    endtask

    task automatic send_reading(input int idx, input int echo);
        send_item(FUNC_READING, 2'(idx), 15'(echo));
    endtask

    // Tick with junk in the ignored fields
    task automatic send_ticks(input int count);
        repeat (count)
            send_item(FUNC_TICK, 2'($urandom_range(3)), 15'($urandom_range(ECHO_TOP)));
    endtask

    // Hold off until every owed event is out and the pipeline is empty
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        drain_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: thr_cm       = cfg_data[9:0];
            CFG_TIMEOUT:   timeout_ms   = cfg_data;
            CFG_COOLDOWN:  cooldown_len = cfg_data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Echo that reads as a hand in range at the current threshold
    function automatic int near_echo();
        int cm;
        if (thr_cm == 0)
            return 1;
        cm = $urandom_range(int'(thr_cm) - 1, 0);
        return cm * CM_DIVISOR + $urandom_range(57, (cm == 0) ? 1 : 0);
    endfunction

    // Echo that reads as out of range: no echo, too long, or too far
    function automatic int far_echo();
        int lo;
        lo = int'(thr_cm) * CM_DIVISOR;
        case ($urandom_range(2))
            0: return 0;
            1: return $urandom_range(ECHO_TOP, ECHO_VALID + 1);
            default: return (lo <= ECHO_VALID) ? $urandom_range(ECHO_VALID, lo) : 0;
        endcase
    endfunction

    // Triggers are ignored during the cooldown that starts at reset
    task automatic test_reset_cooldown();
        send_reading(0, 580);
        send_ticks(1);
        write_reg(CFG_COOLDOWN, 3);
        send_reading(1, 0);
        send_reading(1, 1160);
        send_ticks(1);
        send_reading(1, 1160);
        send_reading(1, 30001);
        send_reading(1, 1160);
    endtask

    // Echo limits, threshold edges and the zero threshold
    task automatic test_echo_range();
        write_reg(CFG_COOLDOWN, 0);
        write_reg(CFG_THRESHOLD, 200);
        send_reading(0, 0);
        send_reading(0, 30001);
        send_reading(0, ECHO_TOP);
        send_reading(0, 11600);
        send_reading(0, 11599);
        send_reading(0, 11599);
        send_reading(2, 1);
        write_reg(CFG_THRESHOLD, 517);
        send_reading(1, 30000);
        send_reading(1, 29985);
        write_reg(CFG_THRESHOLD, 1);
        send_reading(3, 58);
        send_reading(3, 57);
        write_reg(CFG_THRESHOLD, 0);
        send_reading(0, 0);
        send_reading(0, 1);
        send_reading(0, 1);
    endtask

    // Every command pattern, releasing all sensors before each group
    task automatic test_gesture_commands();
        int order [16] = '{0, 2, 1, 3, 2, 0, 3, 1, 0, 1, 2, 3, 0, 3, 2, 1};
        write_reg(CFG_THRESHOLD, 200);
        write_reg(CFG_COOLDOWN, 0);
        for (int i = 0; i < 16; i++)
        begin
            if (i % 4 == 0)
                for (int s = 0; s < 4; s++)
                    send_reading(s, far_echo());
            send_reading(order[i], near_echo());
        end
    endtask

    // Partial gestures aged out at a middle and the shortest timeout
    task automatic test_gesture_timeout();
        write_reg(CFG_TIMEOUT, 3);
        send_reading(0, 0);
        send_reading(0, 2000);
        send_ticks(4);
        write_reg(CFG_TIMEOUT, 1);
        send_reading(1, 0);
        send_reading(1, 2000);
        send_ticks(2);
    endtask

    // Long tick runs: cooldown and timeout edges at wider settings
    task automatic test_long_ticks();
        write_reg(CFG_COOLDOWN, 60);
        write_reg(CFG_TIMEOUT, 70);
        send_ticks(65);
        send_reading(0, 0);
        send_reading(0, 3000);
        send_ticks(69);
        send_reading(2, 0);
        send_reading(2, 3000);
        send_reading(1, 0);
        send_reading(1, 3000);
        send_ticks(75);
        send_reading(1, 0);
        send_reading(1, 3000);
        send_ticks(71);
    endtask

    // One gesture attempt: mostly real patterns with random timing and noise
    task automatic run_gesture();
        int seq [4];
        int len;
        int n;
        len = 2;
        seq = '{0, 0, 0, 0};
        if ($urandom_range(9) < 7)
        begin
            case ($urandom_range(5))
                0: seq = '{0, 2, 0, 0};
                1: seq = '{2, 0, 0, 0};
                2: seq = '{1, 3, 0, 0};
                3: seq = '{3, 1, 0, 0};
                4: begin seq = '{0, 1, 2, 3}; len = 4; end
                default: begin seq = '{0, 3, 2, 1}; len = 4; end
            endcase
        end
        else
        begin
            len = $urandom_range(4, 1);
            foreach (seq[k])
                seq[k] = $urandom_range(3);
        end
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(9) < 7)
                send_reading(seq[k], far_echo());
            if ($urandom_range(19) == 0)
                send_item(1'($urandom), 2'($urandom), 15'($urandom_range(ECHO_TOP)));
            send_reading(seq[k], near_echo());
            send_ticks($urandom_range(2));
            if ($urandom_range(9) == 0)
            begin
                n = int'(timeout_ms) + 2;
                send_ticks($urandom_range((n > 80) ? 80 : n));
            end
        end
        send_ticks($urandom_range(int'(cooldown_len) + 3));
    endtask

    // Random phases over several settings and idle patterns
    task automatic test_random_gestures();
        int phase_end;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: write_reg(CFG_THRESHOLD, 1);
                1: write_reg(CFG_THRESHOLD, 517);
                default: write_reg(CFG_THRESHOLD, $urandom_range(517, 1));
            endcase
            write_reg(CFG_TIMEOUT, (p == 3) ? 1 : $urandom_range(40, 2));
            write_reg(CFG_COOLDOWN, (p % 3 == 0) ? 0 : $urandom_range(30, 1));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end)
                run_gesture();
        end
    endtask

    initial
    begin
        foreach (sensor_hist[k])
        begin
            sensor_hist[k] = 3'd0;
            hand_near[k]   = 1'b0;
        end
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_cooldown();
        test_echo_range();
        test_gesture_commands();
        test_gesture_timeout();
        test_long_ticks();
        test_random_gestures();

        drain_results();
        if (mismatch_count == 0)
            $display("[sensor_sequence_gesture_detector_unit] OK");
        else
            $display("[sensor_sequence_gesture_detector_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ssgd_pkg.sv
rtl/core/sensor_sequence_gesture_detector_unit.sv
rtl/core/ssgd_checker.sv
sim/tb_sensor_sequence_gesture_detector_unit.sv
